[rtl/owip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owip_pkg
// Shared types and constants for the omnicam projection block.
// ----------------------------------------------------------------------------
package owip_pkg;

    localparam int CORDIC_STEPS = 17;
    localparam int STEP_W       = 5;

    localparam logic [2:0] REG_AXIS_INVERT = 3'd0;
    localparam logic [2:0] REG_POLY_TERMS  = 3'd1;
    localparam logic [2:0] REG_AFFINE_C    = 3'd2;
    localparam logic [2:0] REG_AFFINE_D    = 3'd3;
    localparam logic [2:0] REG_AFFINE_E    = 3'd4;
    localparam logic [2:0] REG_CENTER_X    = 3'd5;
    localparam logic [2:0] REG_CENTER_Y    = 3'd6;

    // Datapath operation codes issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_CORDIC_INIT,
        OP_CORDIC_STEP,
        OP_HORNER_INIT,
        OP_HORNER_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_AFF_MUL,
        OP_AFF_SUM
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [6:0] step;
        logic       sel;
    } t_cmd;

    typedef struct packed {
        logic r_zero;
    } t_stat;

    function automatic logic signed [16:0] atan_q16(input logic [STEP_W-1:0] i);
        case (i)
            5'd0:    atan_q16 = 17'sd51472;
            5'd1:    atan_q16 = 17'sd30386;
            5'd2:    atan_q16 = 17'sd16055;
            5'd3:    atan_q16 = 17'sd8150;
            5'd4:    atan_q16 = 17'sd4091;
            5'd5:    atan_q16 = 17'sd2047;
            5'd6:    atan_q16 = 17'sd1024;
            5'd7:    atan_q16 = 17'sd512;
            5'd8:    atan_q16 = 17'sd256;
            5'd9:    atan_q16 = 17'sd128;
            5'd10:   atan_q16 = 17'sd64;
            5'd11:   atan_q16 = 17'sd32;
            5'd12:   atan_q16 = 17'sd16;
            5'd13:   atan_q16 = 17'sd8;
            5'd14:   atan_q16 = 17'sd4;
            5'd15:   atan_q16 = 17'sd2;
            5'd16:   atan_q16 = 17'sd1;
            default: atan_q16 = 17'sd0;
        endcase
    endfunction

endpackage

[rtl/owip_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owip_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module owip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/owip_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owip_ctrl
// Sequencer: walks sqrt, CORDIC, Horner, divide and affine phases.
// ----------------------------------------------------------------------------
module owip_ctrl
    import owip_pkg::*;
#(
    parameter int MAX_TERMS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_action,
    input  logic [4:0] i_poly_terms,
    input  logic       i_out_free,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output logic       o_out_load,
    output t_cmd       o_cmd,
    output logic [$clog2(MAX_TERMS > 1 ? MAX_TERMS : 2)-1:0] o_raddr
);
    localparam int AW = $clog2(MAX_TERMS > 1 ? MAX_TERMS : 2);

    typedef enum logic [3:0] {
        S_IDLE, S_SQRT, S_SQRT_END, S_CORDIC, S_HORN_RD, S_HORN_INIT,
        S_HORN, S_DIV, S_DIV_END, S_AFF_MUL, S_AFF_SUM, S_OUT
    } t_state;

    t_state      r_state, n_state;
    logic [6:0]  r_step, n_step;
    logic [AW:0] r_k, n_k;
    logic [AW:0] r_n, n_n;
    logic [AW:0] w_n;
    t_cmd        n_cmd;
    logic        n_out_load;

    always_comb begin
        if (i_poly_terms == 5'd0) begin
            w_n = (AW+1)'(1);
        end else if (32'(i_poly_terms) > MAX_TERMS) begin
            w_n = (AW+1)'(MAX_TERMS);
        end else begin
            w_n = (AW+1)'(i_poly_terms);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_raddr    = r_k[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_k        = r_k;
        n_n        = r_n;
        n_cmd      = '{op: OP_NONE, step: r_step, sel: 1'b0};
        n_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action) begin
                        n_cmd.op = OP_LOAD;
                    end else begin
                        n_cmd.op = OP_SQRT_INIT;
                        n_n      = w_n;
                        n_step   = '0;
                        n_state  = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                // steps 0..31, then a pass with no step so the root is final
                n_step = r_step + 7'd1;
                if (r_step == 7'd32) begin
                    n_state = S_SQRT_END;
                end else begin
                    n_cmd.op = OP_SQRT_STEP;
                end
            end
            S_SQRT_END: begin
                if (i_stat.r_zero) begin
                    n_state = S_OUT;
                end else begin
                    n_cmd.op = OP_CORDIC_INIT;
                    n_step   = '0;
                    n_state  = S_CORDIC;
                end
            end
            S_CORDIC: begin
                n_cmd.op = OP_CORDIC_STEP;
                n_step   = r_step + 7'd1;
                if (r_step == 7'(CORDIC_STEPS - 1)) begin
                    n_k     = r_n - (AW+1)'(1);
                    n_state = S_HORN_RD;
                end
            end
            S_HORN_RD: begin
                n_state = S_HORN_INIT;
            end
            S_HORN_INIT: begin
                n_cmd.op = OP_HORNER_INIT;
                if (r_k == '0) begin
                    n_step  = '0;
                    n_state = S_DIV;
                end else begin
                    n_k     = r_k - (AW+1)'(1);
                    n_step  = 7'd1;
                    n_state = S_HORN;
                end
            end
            S_HORN: begin
                // wait for the registered read data, then step
                if (r_step[0]) begin
                    n_cmd.op = OP_HORNER_STEP;
                    n_step   = '0;
                    if (r_k == '0) begin
                        n_state = S_DIV;
                    end else begin
                        n_k = r_k - (AW+1)'(1);
                    end
                end else begin
                    n_step = 7'd1;
                end
            end
            S_DIV: begin
                // step 0 init, 1..64 iterations, two dividends (sel)
                if (r_step == 7'd0) begin
                    n_cmd.op = OP_DIV_INIT;
                end else begin
                    n_cmd.op = OP_DIV_STEP;
                end
                n_cmd.sel = r_k[0];
                n_step    = r_step + 7'd1;
                if (r_step == 7'd64) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                n_cmd.op  = OP_DIV_DONE;
                n_cmd.sel = r_k[0];
                n_step    = '0;
                if (r_k[0]) begin
                    n_k     = '0;
                    n_state = S_AFF_MUL;
                end else begin
                    n_k     = (AW+1)'(1);
                    n_state = S_DIV;
                end
            end
            S_AFF_MUL: begin
                n_cmd.op = OP_AFF_MUL;
                n_state  = S_AFF_SUM;
            end
            S_AFF_SUM: begin
                n_cmd.op = OP_AFF_SUM;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    n_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_k        <= '0;
            r_n        <= '0;
            o_cmd      <= '{op: OP_NONE, step: 7'd0, sel: 1'b0};
            o_out_load <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_k        <= n_k;
            r_n        <= n_n;
            o_cmd      <= n_cmd;
            o_out_load <= n_out_load;
        end
    end
endmodule

[rtl/owip_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owip_datapath
// Shared iterative sqrt, CORDIC, Horner MAC, divider and affine stage.
// ----------------------------------------------------------------------------
module owip_datapath
    import owip_pkg::*;
(
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    input  logic [2:0]         i_axis_invert,
    input  logic signed [31:0] i_coef,
    input  logic signed [31:0] i_affine_c,
    input  logic signed [31:0] i_affine_d,
    input  logic signed [31:0] i_affine_e,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    output t_stat              o_stat,
    output logic signed [31:0] o_image_x,
    output logic signed [31:0] o_image_y,
    output logic               o_saturated
);
    localparam logic signed [65:0] S32MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32MIN = -66'sd2147483648;

    logic signed [32:0] r_x, r_y, r_z;
    logic [63:0] r_rem, r_root;
    logic signed [34:0] r_cx, r_cy;
    logic signed [19:0] r_ang;
    logic signed [31:0] r_acc;
    logic               r_sat;
    logic signed [31:0] r_u, r_v;
    logic [65:0] r_dq;
    logic [33:0] r_dr;
    logic        r_dneg;
    logic signed [63:0] r_p0, r_p1, r_p2;
    logic signed [31:0] r_ox, r_oy;

    logic [31:0] w_r;
    assign w_r = r_root[31:0];
    assign o_stat.r_zero = (w_r == 32'd0);

    // squares of the raw coordinates (sign flips do not change them)
    logic signed [63:0] w_sqx, w_sqy;
    assign w_sqx = i_px * i_px;
    assign w_sqy = i_py * i_py;

    // sqrt: two bits a step over the 64-bit square sum
    logic [63:0] w_bit;
    logic [63:0] w_trial;
    assign w_bit   = 64'd1 << (7'd62 - {i_cmd.step[5:0], 1'b0});
    assign w_trial = r_root + w_bit;

    // CORDIC shifted terms (arithmetic shift == floor)
    logic signed [34:0] w_dx, w_dy;
    assign w_dx = r_cy >>> i_cmd.step[4:0];
    assign w_dy = r_cx >>> i_cmd.step[4:0];

    // Horner MAC; theta stays within about +-1.75 rad, well inside r_ang
    logic signed [63:0] w_prod;
    logic signed [65:0] w_hsum;
    assign w_prod = r_acc * r_ang;
    assign w_hsum = 66'(w_prod >>> 16) + 66'(i_coef);

    // divider: magnitude of (coord * rho) / r, restoring
    logic signed [64:0] w_num;
    assign w_num = (i_cmd.sel ? r_y : r_x) * r_acc;
    logic [65:0] w_dnum;
    assign w_dnum = w_num[64] ? 66'(-w_num) : 66'(w_num);
    logic [33:0] w_dshift;
    logic [33:0] w_dsub;
    assign w_dshift = {r_dr[32:0], r_dq[65]};
    assign w_dsub   = w_dshift - {2'b0, w_r};
    logic signed [65:0] w_q;
    assign w_q = r_dneg ? -$signed(r_dq) : $signed(r_dq);
    logic signed [31:0] w_qc;
    assign w_qc = (w_q > S32MAX) ? 32'sh7fffffff :
                  (w_q < S32MIN) ? 32'sh80000000 : w_q[31:0];

    logic signed [65:0] w_ox, w_oy;
    assign w_ox = 66'(r_p0 >>> 16) + 66'(r_p1 >>> 16) + 66'(i_center_x);
    assign w_oy = 66'(r_p2 >>> 16) + 66'(r_v) + 66'(i_center_y);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_SQRT_INIT: begin
                r_x    <= i_axis_invert[0] ? -33'(i_px) : 33'(i_px);
                r_y    <= i_axis_invert[1] ? -33'(i_py) : 33'(i_py);
                r_z    <= i_axis_invert[2] ? -33'(i_pz) : 33'(i_pz);
                r_root <= '0;
                r_sat  <= 1'b0;
                r_rem  <= 64'(w_sqx) + 64'(w_sqy);
            end
            OP_SQRT_STEP: begin
                if (r_rem >= w_trial) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + w_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            OP_CORDIC_INIT: begin
                r_cx  <= 35'(w_r);
                r_cy  <= 35'(r_z);
                r_ang <= '0;
            end
            OP_CORDIC_STEP: begin
                if (!r_cy[34]) begin
                    r_cx  <= r_cx + w_dx;
                    r_cy  <= r_cy - w_dy;
                    r_ang <= r_ang + 20'(atan_q16(i_cmd.step[4:0]));
                end else begin
                    r_cx  <= r_cx - w_dx;
                    r_cy  <= r_cy + w_dy;
                    r_ang <= r_ang - 20'(atan_q16(i_cmd.step[4:0]));
                end
            end
            OP_HORNER_INIT: r_acc <= i_coef;
            OP_HORNER_STEP: begin
                if (w_hsum > S32MAX) begin
                    r_acc <= 32'sh7fffffff; r_sat <= 1'b1;
                end else if (w_hsum < S32MIN) begin
                    r_acc <= 32'sh80000000; r_sat <= 1'b1;
                end else begin
                    r_acc <= w_hsum[31:0];
                end
            end
            OP_DIV_INIT: begin
                // top 2 bits of the magnitude are zero; start at bit 63
                r_dq   <= {w_dnum[63:0], 2'b00};
                r_dr   <= '0;
                r_dneg <= w_num[64];
            end
            OP_DIV_STEP: begin
                if (!w_dsub[33]) begin
                    r_dr <= w_dsub;
                    r_dq <= {r_dq[64:0], 1'b1};
                end else begin
                    r_dr <= w_dshift;
                    r_dq <= {r_dq[64:0], 1'b0};
                end
            end
            OP_DIV_DONE: begin
                // 64 steps leave the quotient in the low 64 bits
                if (i_cmd.sel) r_v <= w_qc; else r_u <= w_qc;
                if (w_q > S32MAX || w_q < S32MIN) r_sat <= 1'b1;
            end
            OP_AFF_MUL: begin
                r_p0 <= r_u * i_affine_c;
                r_p1 <= r_v * i_affine_d;
                r_p2 <= r_u * i_affine_e;
            end
            OP_AFF_SUM: begin
                if (w_ox > S32MAX) begin
                    r_ox <= 32'sh7fffffff; r_sat <= 1'b1;
                end else if (w_ox < S32MIN) begin
                    r_ox <= 32'sh80000000; r_sat <= 1'b1;
                end else begin
                    r_ox <= w_ox[31:0];
                end
                if (w_oy > S32MAX) begin
                    r_oy <= 32'sh7fffffff; r_sat <= 1'b1;
                end else if (w_oy < S32MIN) begin
                    r_oy <= 32'sh80000000; r_sat <= 1'b1;
                end else begin
                    r_oy <= w_oy[31:0];
                end
            end
            default: ;
        endcase
    end

    // on-axis point: centre, no saturation
    assign o_image_x   = o_stat.r_zero ? i_center_x : r_ox;
    assign o_image_y   = o_stat.r_zero ? i_center_y : r_oy;
    assign o_saturated = o_stat.r_zero ? 1'b0 : r_sat;
endmodule

[rtl/omnicam_world_to_image_projection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omnicam_world_to_image_projection
// Projects a 3-D point onto an omnidirectional camera image, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one beat per item. tuser = action
//   (0 project, 1 load coefficient). tdata carries point_x, point_y,
//   point_z, coef_index, coef_value from bit 0 up.
//   Output stream (m_axis_*): one beat per project item, tdata carries
//   image_x, image_y, saturated from bit 0 up. Load items give no beat.
//   Configuration: i_cfg_we / i_cfg_index / i_cfg_data, written at idle.
// Flow: one item at a time. A load is written to the coefficient RAM as
//   it is accepted, and the sequencer stays idle. A projection runs a
//   square root (2 bits a step, then a settle step), an on-axis check,
//   17 CORDIC steps, a coefficient RAM read, the Horner terms read from
//   the coefficient RAM, a restoring divide for x*rho/r and then y*rho/r,
//   an affine multiply and sum, and the output load. An on-axis point
//   skips to the result after the square root. The next beat can be
//   taken at the same edge at which tvalid rises.
// Reset: config returns to defaults; coefficient RAM is not cleared and
//   must be loaded before use.
// Stall: a finished result sits in the output register until m_axis_tready.
//   Meanwhile one more item is taken and computed; it then waits in the
//   sequencer, and no input is taken until the held beat leaves.
// ----------------------------------------------------------------------------
module omnicam_world_to_image_projection
    import owip_pkg::*;
#(
    parameter int MAX_TERMS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64], coef_index[99:96],
    // coef_value[131:100], zero pad
    input  logic [135:0]  s_axis_tdata,
    input  logic          s_axis_tuser,   // action
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // image_x[31:0], image_y[63:32], saturated[64], zero pad
    output logic [71:0]   m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    localparam int AW = $clog2(MAX_TERMS > 1 ? MAX_TERMS : 2);

    logic [2:0]  r_axis_invert;
    logic [4:0]  r_poly_terms;
    logic signed [31:0] r_affine_c, r_affine_d, r_affine_e, r_center_x, r_center_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_invert <= 3'd0;
            r_poly_terms  <= 5'd1;
            r_affine_c    <= 32'sd65536;
            r_affine_d    <= '0;
            r_affine_e    <= '0;
            r_center_x    <= '0;
            r_center_y    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_AXIS_INVERT: r_axis_invert <= i_cfg_data[2:0];
                REG_POLY_TERMS:  r_poly_terms  <= i_cfg_data[4:0];
                REG_AFFINE_C:    r_affine_c    <= i_cfg_data;
                REG_AFFINE_D:    r_affine_d    <= i_cfg_data;
                REG_AFFINE_E:    r_affine_e    <= i_cfg_data;
                REG_CENTER_X:    r_center_x    <= i_cfg_data;
                REG_CENTER_Y:    r_center_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // point capture
    logic signed [31:0] r_px, r_py, r_pz;
    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_px <= s_axis_tdata[31:0];
            r_py <= s_axis_tdata[63:32];
            r_pz <= s_axis_tdata[95:64];
        end
    end

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_out_load;
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_coef;
    logic          w_we;
    logic [3:0]    w_idx;
    assign w_idx = s_axis_tdata[99:96];
    assign w_we  = s_acc && s_axis_tuser && (32'(w_idx) < MAX_TERMS);

    owip_ram #(.WIDTH(32), .DEPTH(MAX_TERMS > 1 ? MAX_TERMS : 2)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(w_idx)),
        .i_wdata (s_axis_tdata[131:100]),
        .i_raddr (w_raddr),
        .o_rdata (w_coef)
    );

    logic r_mvalid;
    logic [64:0] r_mdata;

    owip_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_action     (s_axis_tuser),
        .i_poly_terms (r_poly_terms),
        .i_out_free   (!r_mvalid || m_axis_tready),
        .i_stat       (w_stat),
        .o_in_ready   (s_axis_tready),
        .o_out_load   (w_out_load),
        .o_cmd        (w_cmd),
        .o_raddr      (w_raddr)
    );

    logic signed [31:0] w_ix, w_iy;
    logic               w_sat;

    owip_datapath u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_px          (r_px),
        .i_py          (r_py),
        .i_pz          (r_pz),
        .i_axis_invert (r_axis_invert),
        .i_coef        (w_coef),
        .i_affine_c    (r_affine_c),
        .i_affine_d    (r_affine_d),
        .i_affine_e    (r_affine_e),
        .i_center_x    (r_center_x),
        .i_center_y    (r_center_y),
        .o_stat        (w_stat),
        .o_image_x     (w_ix),
        .o_image_y     (w_iy),
        .o_saturated   (w_sat)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_out_load) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_mdata <= {w_sat, w_iy, w_ix};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {7'd0, r_mdata};

    // a load never produces an output beat
    a_load_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_axis_tuser) |=> !w_out_load)
        else $error("load produced a result");
    // results are not overwritten while stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && !m_axis_tready) |-> !w_out_load)
        else $error("output overrun");
    // no input taken while a projection is in progress
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !s_axis_tuser) |=> !s_axis_tready)
        else $error("input accepted mid-item");
endmodule

[tb/omnicam_world_to_image_projection_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omnicam_world_to_image_projection_tb
// Self-checking bench for the omnicam world-to-image projection block.
// Drives coefficient loads and point projections over the input stream,
// rewrites the configuration between phases, and checks every output beat
// against a bit-exact Q16.16 projection computed inside the bench.
// ----------------------------------------------------------------------------
module omnicam_world_to_image_projection_tb;
    import owip_pkg::*;

    localparam int TERMS      = 16;
    localparam int WDOG_LIMIT = 20000;   // cycles without any beat or config write
    localparam int HOLD_LEN   = 800;     // long receiver hold-off
    localparam bit ACT_PROJ   = 1'b0;
    localparam bit ACT_LOAD   = 1'b1;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [135:0]  s_axis_tdata = '0;    // x, y, z, coef_index, coef_value
    logic          s_axis_tuser = 1'b0;  // action
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b1;
    logic [71:0]   m_axis_tdata;         // image_x, image_y, saturated
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    omnicam_world_to_image_projection dut (.*);

    // Bench copy of configuration and coefficient store.
    logic [2:0]         axis_inv = 3'd0;
    logic [4:0]         n_terms  = 5'd1;
    logic signed [31:0] aff_c = 32'sd65536, aff_d = '0, aff_e = '0;
    logic signed [31:0] ctr_x = '0, ctr_y = '0;
    logic signed [31:0] coef_tab [TERMS];

    logic [64:0] image_q [$];  // {saturated, image_y, image_x} per projection

    bit gaps_on = 1'b1;        // random idling on both sides
    int hold_reqs = 0, hold_done = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    longint cordic_ang [CORDIC_STEPS] = '{51472, 30386, 16055, 8150, 4091, 2047,
                                         1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    function automatic longint clamp_s32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Full projection of one world point, bit exact.
    function automatic logic [64:0] project_point(logic signed [31:0] wx,
                                                  logic signed [31:0] wy,
                                                  logic signed [31:0] wz);
        longint px, py, pz, r, cx, cy, dx, dy, theta, acc, u, v, ox, oy;
        longint unsigned sq, root, bt;
        int n;
        bit sat;
        sat = 1'b0;
        px = wx; py = wy; pz = wz;
        if (axis_inv[0]) px = -px;
        if (axis_inv[1]) py = -py;
        if (axis_inv[2]) pz = -pz;
        sq = longint'(px * px) + longint'(py * py);
        // integer square root, two bits per pass
        root = 0;
        bt = 64'd1 << 62;
        while (bt > sq) bt >>= 2;
        while (bt != 0) begin
            if (sq >= root + bt) begin
                sq -= root + bt;
                root = (root >> 1) + bt;
            end else begin
                root >>= 1;
            end
            bt >>= 2;
        end
        r = root;
        if (r == 0) begin
            ox = ctr_x;
            oy = ctr_y;
        end else begin
            // vectoring CORDIC on (r, z): theta = atan(z / r)
            cx = r; cy = pz; theta = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0) begin
                    cx += dx; cy -= dy; theta += cordic_ang[i];
                end else begin
                    cx -= dx; cy += dy; theta -= cordic_ang[i];
                end
            end
            n = n_terms;
            if (n < 1) n = 1;
            if (n > TERMS) n = TERMS;
            acc = coef_tab[n-1];
            for (int k = n - 2; k >= 0; k--)
                acc = clamp_s32(((acc * theta) >>> 16) + longint'(coef_tab[k]), sat);
            u = clamp_s32((px * acc) / r, sat);
            v = clamp_s32((py * acc) / r, sat);
            ox = ((u * longint'(aff_c)) >>> 16) + ((v * longint'(aff_d)) >>> 16)
               + longint'(ctr_x);
            oy = ((u * longint'(aff_e)) >>> 16) + v + longint'(ctr_y);
            ox = clamp_s32(ox, sat);
            oy = clamp_s32(oy, sat);
        end
        return {sat, oy[31:0], ox[31:0]};
    endfunction

    // One input beat; prediction happens at the accepting edge.
    task automatic send_beat(bit act, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [3:0] idx, logic [31:0] val);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {4'b0, val, idx, z, y, x};
        s_axis_tuser  = act;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (act == ACT_LOAD)
            coef_tab[idx] = val;
        else
            image_q.push_back(project_point(x, y, z));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Drain, then let a load that may still be in flight settle.
    task automatic wait_idle();
        end_burst();
        while (image_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        wait_idle();
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_AXIS_INVERT: axis_inv = val[2:0];
            REG_POLY_TERMS:  n_terms  = val[4:0];
            REG_AFFINE_C:    aff_c    = val;
            REG_AFFINE_D:    aff_d    = val;
            REG_AFFINE_E:    aff_e    = val;
            REG_CENTER_X:    ctr_x    = val;
            REG_CENTER_Y:    ctr_y    = val;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'd0;
            3, 4:    return $urandom();
            default: return $urandom() >>> $urandom_range(4, 24)
                            ^ ($urandom_range(0, 1) ? 32'hffff_ffff : 32'h0);
        endcase
    endfunction

    // Moderate coefficients keep most results in range; some are extreme.
    function automatic logic [31:0] rand_coef();
        logic signed [31:0] c;
        if ($urandom_range(0, 9) == 0) return $urandom();
        c = $signed($urandom()) >>> $urandom_range(6, 20);
        return c;
    endfunction

    function automatic logic [31:0] rand_reg(logic [2:0] idx);
        case (idx)
            REG_AXIS_INVERT: return $urandom_range(0, 7);
            REG_POLY_TERMS:  return $urandom_range(0, 31);
            REG_CENTER_X, REG_CENTER_Y:
                return ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 2000) << 16;
            default:
                return ($urandom_range(0, 5) == 0) ? $urandom()
                     : $signed($urandom()) >>> $urandom_range(12, 16);
        endcase
    endfunction

    task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send_beat(ACT_PROJ, x, y, z, 4'($urandom()), $urandom());
    endtask

    task automatic load_coef(logic [3:0] idx, logic [31:0] val);
        send_beat(ACT_LOAD, $urandom(), $urandom(), $urandom(), idx, val);
    endtask

    // --- tests ---------------------------------------------------------------

    // Fill every slot so no projection can read an unwritten entry.
    task automatic test_coef_fill();
        load_coef(4'd0, 32'sd300 << 16);
        load_coef(4'd1, 32'h8000_0000);
        load_coef(4'd2, 32'h7fff_ffff);
        for (int i = 3; i < TERMS; i++) load_coef(i[3:0], rand_coef());
        load_coef(4'd1, 32'shfff0_0000);   // rewrite a slot
    endtask

    // Default config, then field extremes and the on-axis point, also under 16 and 3 terms.
    task automatic test_directed_points();
        project(32'd0, 32'd0, 32'h7fff_ffff);       // on axis
        project(32'd0, 32'd0, 32'h8000_0000);
        project(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        project(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        project(32'h0001_0000, 32'd0, 32'd0);
        project(32'd0, 32'hffff_ffff, 32'h0001_0000);
        project(32'd1, 32'd0, 32'h7fff_ffff);
        write_reg(REG_POLY_TERMS, 32'd16);
        project(32'h0010_0000, 32'hfff0_0000, 32'h0008_0000);
        project(32'h8000_0000, 32'd0, 32'd0);
        write_reg(REG_POLY_TERMS, 32'd3);
        project(32'h0100_0000, 32'h0100_0000, 32'hff00_0000);
        project(32'h7fff_ffff, 32'h8000_0000, 32'd0);
    endtask

    // Every register, its extremes, and out-of-range term counts.
    task automatic test_config_sweep();
        logic [31:0] ext [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff};
        for (int a = 0; a < 8; a++) begin
            write_reg(REG_AXIS_INVERT, a);
            project(32'h8000_0000, 32'h0003_0000, 32'h8000_0000);
        end
        foreach (ext[i]) begin
            for (int r = REG_AFFINE_C; r <= REG_CENTER_Y; r++) write_reg(r[2:0], ext[i]);
            project(32'h0004_0000, 32'hfffc_0000, 32'h0001_0000);
            project(32'd0, 32'd0, 32'd5);
        end
        write_reg(REG_POLY_TERMS, 32'd0);    // clamps up to one term
        project(32'h0002_0000, 32'h0002_0000, 32'd0);
        write_reg(REG_POLY_TERMS, 32'd31);   // clamps down to all terms
        project(32'h0002_0000, 32'h0002_0000, 32'd0);
        write_reg(REG_AXIS_INVERT, 32'd0);
        write_reg(REG_AFFINE_C, 32'd65536);
        write_reg(REG_AFFINE_D, 32'd0);
        write_reg(REG_AFFINE_E, 32'd0);
        write_reg(REG_CENTER_X, 32'd640 << 16);
        write_reg(REG_CENTER_Y, 32'd480 << 16);
    endtask

    task automatic random_items(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 6) == 0)
                load_coef(4'($urandom()), rand_coef());
            else
                project(rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    // Phases of random items, each after a random subset of the registers is rewritten.
    task automatic test_random_sweep();
        for (int p = 0; p < 7; p++) begin
            write_reg(3'($urandom_range(0, 6)), 32'd0);
            for (int r = 0; r <= REG_CENTER_Y; r++)
                if ($urandom_range(0, 1)) write_reg(r[2:0], rand_reg(r[2:0]));
            random_items(200);
        end
    endtask

    // Receiver holds off long while the sender keeps offering items.
    task automatic test_backpressure();
        hold_reqs++;
        random_items(30);
        end_burst();
        while (hold_done != hold_reqs) @(negedge i_clk);
    endtask

    // Sender stops until every result is back, then resumes.
    task automatic test_drain_pause();
        random_items(20);
        end_burst();
        while (image_q.size() != 0) @(negedge i_clk);
        random_items(20);
    endtask

    // No idling on either side for the final stretch.
    task automatic test_quiet_tail();
        wait_idle();
        gaps_on = 1'b0;
        random_items(150);
        end_burst();
    endtask

    // --- output side ---------------------------------------------------------

    int stall_left = 0;
    int hold_left  = 0;
    always @(negedge i_clk) begin
        if (hold_done != hold_reqs && hold_left == 0) begin
            hold_left = HOLD_LEN;
            hold_done = hold_reqs - 1;       // marked done when the count runs out
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
            if (hold_left == 0) hold_done = hold_reqs;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (gaps_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 9);
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each output beat with the oldest pending projection.
    always @(posedge i_clk) begin
        logic [64:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (image_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat: %h", m_axis_tdata);
            end else begin
                want = image_q.pop_front();
                if (m_axis_tdata[31:0] !== want[31:0] || m_axis_tdata[63:32] !== want[63:32]
                    || m_axis_tdata[64] !== want[64]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: x exp %h got %h, y exp %h got %h, sat exp %b got %b",
                                 want[31:0], m_axis_tdata[31:0], want[63:32],
                                 m_axis_tdata[63:32], want[64], m_axis_tdata[64]);
                end
            end
        end
    end

    // Watchdog: any beat on either side or a config write restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles = 0;
        else if (++quiet_cycles >= WDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_coef_fill();
        test_directed_points();
        test_config_sweep();
        test_backpressure();
        test_random_sweep();
        test_drain_pause();
        test_quiet_tail();
        while (image_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (mismatches == 0 && image_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
